// ----- sv/keyed_value_table_top_defines.svh -----
// Assertion macros for the keyed value table.
`ifndef KEYED_VALUE_TABLE_TOP_DEFINES_SVH
`define KEYED_VALUE_TABLE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define KVT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("keyed value table check failed");
`define KVT_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("keyed value table forbidden condition");
`else
`define KVT_ASSERT(lbl, prop)
`define KVT_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ----- sv/kvt_pkg.sv -----
// Shared widths, codes and controller/datapath structs for the keyed value table.
`default_nettype none
package kvt_pkg;

    localparam int OP_W     = 3;
    localparam int TAG_W    = 32;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int TALLY_W  = 6;

    localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
    localparam logic [OP_W-1:0] OP_ERASE     = 3'd1;
    localparam logic [OP_W-1:0] OP_ERASE_ALL = 3'd2;
    localparam logic [OP_W-1:0] OP_GET       = 3'd3;
    localparam logic [OP_W-1:0] OP_HAS       = 3'd4;
    localparam logic [OP_W-1:0] OP_COUNT     = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

    typedef struct packed {
        logic capture;
        logic clear_all;
        logic scan;
        logic shift_init;
        logic shift;
        logic insert;
        logic dec;
        logic load_out;
    } kvt_cmd_t;

    typedef struct packed {
        logic is_insert;
        logic is_erase;
        logic is_erase_all;
        logic is_search;
        logic full;
        logic scan_done;
        logic hit_any;
        logic shift_done;
        logic out_free;
    } kvt_sts_t;

endpackage
`default_nettype wire

// ----- sv/kvt_req_if.sv -----
// Request channel: operation, key and value word with valid/ready.
`default_nettype none
interface kvt_req_if import kvt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [TAG_W-1:0]  key_tag;
    logic [WORD_W-1:0] value_word;

    modport source (output valid, operation, key_tag, value_word, input ready);
    modport sink   (input valid, operation, key_tag, value_word, output ready);
endinterface
`default_nettype wire

// ----- sv/kvt_rsp_if.sv -----
// Response channel: status, lookup result and occupancy with valid/ready.
`default_nettype none
interface kvt_rsp_if import kvt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [WORD_W-1:0]   value_out;
    logic [TALLY_W-1:0]  match_count;
    logic [TALLY_W-1:0]  occupancy;

    modport source (output valid, status, found, value_out, match_count, occupancy,
                    input ready);
    modport sink   (input valid, status, found, value_out, match_count, occupancy,
                    output ready);
endinterface
`default_nettype wire

// ----- sv/kvt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- sv/kvt_ctrl.sv -----
// Request sequencer: decode, scan, insert, shift-down and result hand-off.
`default_nettype none
module kvt_ctrl import kvt_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_fire,
    output logic          in_ready,
    input  wire kvt_sts_t sts,
    output kvt_cmd_t      cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_SCAN   = 6'b000100,
        S_INSERT = 6'b001000,
        S_SHIFT  = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.is_insert && sts.full)
                begin
                    state_next = S_RESULT;
                end
                else if (sts.is_erase_all)
                begin
                    cmd.clear_all = 1'b1;
                    state_next    = S_RESULT;
                end
                else if (sts.is_search)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    if (sts.is_insert && !sts.hit_any)
                    begin
                        state_next = S_INSERT;
                    end
                    else if (sts.is_erase && sts.hit_any)
                    begin
                        cmd.shift_init = 1'b1;
                        state_next     = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_RESULT;
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (sts.shift_done)
                begin
                    cmd.dec    = 1'b1;
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/kvt_datapath.sv -----
// Entry store, scan pointer, key/value compare, tally and result register.
`default_nettype none
module kvt_datapath import kvt_pkg::*; #(
    parameter int CAPACITY    = 32,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire kvt_cmd_t            cmd,
    output kvt_sts_t                 sts,
    input  wire logic [OP_W-1:0]     operation,
    input  wire logic [TAG_W-1:0]    key_tag,
    input  wire logic [WORD_W-1:0]   value_word,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic      [STATUS_W-1:0] status,
    output logic                     found,
    output logic      [WORD_W-1:0]   value_out,
    output logic      [TALLY_W-1:0]  match_count,
    output logic      [TALLY_W-1:0]  occupancy
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = KEY_WIDTH + VALUE_WIDTH;

    // request and scan control
    logic [OP_W-1:0]        op_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          ptr_reg, ptr_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [AW-1:0]          rd_idx_reg, rd_idx_next;
    logic                   hit_reg, hit_next;
    logic [VALUE_WIDTH-1:0] hit_val_reg;
    logic                   full_reg, full_next;
    logic [TALLY_W-1:0]     tally_reg, tally_next;
    logic                   out_vld_reg, out_vld_next;

    logic [STATUS_W-1:0]    status_reg;
    logic                   found_reg;
    logic [WORD_W-1:0]      value_out_reg;
    logic [TALLY_W-1:0]     match_reg;
    logic [TALLY_W-1:0]     occ_reg;

    // memory ports
    logic                   we;
    logic [AW-1:0]          waddr;
    logic [EW-1:0]          wdata;
    logic [EW-1:0]          rdata;
    logic [KEY_WIDTH-1:0]   rd_key;
    logic [VALUE_WIDTH-1:0] rd_val;

    logic is_insert, is_erase, is_get, is_has, is_count;
    logic ptr_at_end, rd_issue, key_hit, val_hit;
    logic [STATUS_W-1:0] status_calc;

    kvt_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (rdata)
    );

    assign rd_key = rdata[EW-1:VALUE_WIDTH];
    assign rd_val = rdata[VALUE_WIDTH-1:0];

    assign is_insert = (op_reg == OP_INSERT);
    assign is_erase  = (op_reg == OP_ERASE);
    assign is_get    = (op_reg == OP_GET);
    assign is_has    = (op_reg == OP_HAS);
    assign is_count  = (op_reg == OP_COUNT);

    assign ptr_at_end = (ptr_reg == count_reg);
    assign rd_issue   = (cmd.scan || cmd.shift) && !ptr_at_end;
    assign key_hit    = rd_vld_reg && !is_count && (rd_key == key_reg);
    assign val_hit    = rd_vld_reg && is_count && (rd_val == val_reg);

    assign sts.is_insert    = is_insert;
    assign sts.is_erase     = is_erase;
    assign sts.is_erase_all = (op_reg == OP_ERASE_ALL);
    assign sts.is_search    = is_insert || is_erase || is_get || is_has || is_count;
    assign sts.full         = full_reg;
    assign sts.scan_done    = key_hit || (ptr_at_end && !rd_vld_reg);
    assign sts.hit_any      = hit_reg || key_hit;
    assign sts.shift_done   = ptr_at_end && !rd_vld_reg;
    assign sts.out_free     = !out_vld_reg || out_ready;

    // store writes: append on insert, move down one slot while shifting
    always_comb
    begin
        we    = 1'b0;
        waddr = count_reg[AW-1:0];
        wdata = {key_reg, val_reg};
        if (cmd.insert)
        begin
            we = 1'b1;
        end
        else if (cmd.shift && rd_vld_reg)
        begin
            we    = 1'b1;
            waddr = rd_idx_reg - AW'(1);
            wdata = rdata;
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        rd_vld_next = rd_issue;
        rd_idx_next = rd_idx_reg;
        hit_next    = hit_reg;
        full_next   = full_reg;
        tally_next  = tally_reg;

        if (rd_issue)
        begin
            ptr_next    = ptr_reg + CW'(1);
            rd_idx_next = ptr_reg[AW-1:0];
        end
        if (cmd.capture)
        begin
            ptr_next   = '0;
            hit_next   = 1'b0;
            tally_next = '0;
            full_next  = (count_reg == CW'(CAPACITY));
        end
        if (cmd.scan && key_hit)
        begin
            hit_next = 1'b1;
        end
        if (cmd.scan && val_hit)
        begin
            tally_next = tally_reg + TALLY_W'(1);
        end
        // erase resumes reading just past the matching slot
        if (cmd.shift_init)
        begin
            ptr_next = CW'(rd_idx_reg) + CW'(1);
        end
        if (cmd.insert)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.dec)
        begin
            count_next = count_reg - CW'(1);
        end
        else if (cmd.clear_all)
        begin
            count_next = '0;
        end
    end

    always_comb
    begin
        status_calc = ST_OK;
        if (is_insert)
        begin
            if (full_reg)
            begin
                status_calc = ST_FULL;
            end
            else if (hit_reg)
            begin
                status_calc = ST_DUP;
            end
        end
        else if ((is_erase || is_get) && !hit_reg)
        begin
            status_calc = ST_MISS;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (cmd.load_out)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            ptr_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            hit_reg     <= 1'b0;
            full_reg    <= 1'b0;
            tally_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            ptr_reg     <= ptr_next;
            rd_vld_reg  <= rd_vld_next;
            hit_reg     <= hit_next;
            full_reg    <= full_next;
            tally_reg   <= tally_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        if (cmd.capture)
        begin
            op_reg  <= operation;
            key_reg <= KEY_WIDTH'(key_tag);
            val_reg <= VALUE_WIDTH'(value_word);
        end
        if (cmd.scan && key_hit)
        begin
            hit_val_reg <= rd_val;
        end
        if (cmd.load_out)
        begin
            status_reg    <= status_calc;
            found_reg     <= (is_erase || is_get || is_has) && hit_reg;
            value_out_reg <= (is_get && hit_reg) ? WORD_W'(hit_val_reg) : '0;
            match_reg     <= is_count ? tally_reg : '0;
            occ_reg       <= TALLY_W'(count_reg);
        end
    end

    assign out_valid   = out_vld_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign value_out   = value_out_reg;
    assign match_count = match_reg;
    assign occupancy   = occ_reg;

endmodule
`default_nettype wire

// ----- sv/keyed_value_table_top.sv -----
// Keyed value table: packed key/value store with scan-based lookup and shift-down erase.
// A lookup or count scans the stored entries in order; a key hit stops the scan early.
// Insert adds a write after the scan, erase a shift-down pass on a hit; erase-all skips the scan.
// Throughput: one request in flight; the next word is taken once the previous result is
// registered. Scanning the RAM's one read port at one entry per cycle sets the rate.
// Reset clears the entry count and handshake state; stored entries are not cleared.
`default_nettype none
`include "keyed_value_table_top_defines.svh"
module keyed_value_table_top import kvt_pkg::*; #(
    parameter int CAPACITY    = 32,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    kvt_req_if.sink    req,
    kvt_rsp_if.source  rsp
);

    kvt_cmd_t cmd;
    kvt_sts_t sts;
    logic     in_ready;
    logic     req_fire;

    assign req.ready = in_ready;
    assign req_fire  = req.valid && in_ready;

    kvt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_fire (req_fire),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    kvt_datapath #(
        .CAPACITY    (CAPACITY),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .operation   (req.operation),
        .key_tag     (req.key_tag),
        .value_word  (req.value_word),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .status      (rsp.status),
        .found       (rsp.found),
        .value_out   (rsp.value_out),
        .match_count (rsp.match_count),
        .occupancy   (rsp.occupancy)
    );

    `KVT_ASSERT(a_cmd_excl, $onehot0({cmd.capture, cmd.scan, cmd.shift, cmd.insert, cmd.load_out}))
    `KVT_ASSERT_NEVER(a_no_insert_full, cmd.insert && sts.full)
    `KVT_ASSERT(a_no_instant_result, req_fire |=> !cmd.load_out)

endmodule
`default_nettype wire

// ----- dv/keyed_value_table_top_tb.sv -----
// Self-checking testbench for the keyed value table: directed, fill/drain and random traffic.
module keyed_value_table_top_tb;
    import kvt_pkg::*;

    localparam int CAPACITY = 32;
    localparam int IDLE_PCT = 14;
    // operation codes the block treats as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [WORD_W-1:0]   value_out;
        logic [TALLY_W-1:0]  match_count;
        logic [TALLY_W-1:0]  occupancy;
    } table_reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    kvt_req_if req ();
    kvt_rsp_if rsp ();

    keyed_value_table_top #(
        .CAPACITY    (CAPACITY),
        .KEY_WIDTH   (TAG_W),
        .VALUE_WIDTH (WORD_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shadow copy of the table contents
    logic [TAG_W-1:0]  shadow_keys [CAPACITY];
    logic [WORD_W-1:0] shadow_vals [CAPACITY];
    int                shadow_count = 0;

    table_reply_t awaited_replies [$];
    bit           no_idle = 1'b0;
    int           failures = 0;
    int           requests_sent = 0;
    int           replies_checked = 0;
    int           full_refusals = 0;
    int           dup_refusals = 0;
    int           key_misses = 0;
    int           key_hits = 0;
    int           peak_occupancy = 0;

    function automatic int slot_of(input logic [TAG_W-1:0] key);
        for (int i = 0; i < shadow_count; i++)
        begin
            if (shadow_keys[i] == key)
                return i;
        end
        return -1;
    endfunction

    function automatic table_reply_t apply_to_shadow_table(input logic [OP_W-1:0] op,
                                                           input logic [TAG_W-1:0] key,
                                                           input logic [WORD_W-1:0] val);
        table_reply_t r;
        int slot;
        r = '0;
        slot = slot_of(key);
        case (op)
            OP_INSERT:
            begin
                // fullness wins over the duplicate test
                if (shadow_count >= CAPACITY)
                begin
                    r.status = ST_FULL;
                    full_refusals++;
                end
                else if (slot >= 0)
                begin
                    r.status = ST_DUP;
                    dup_refusals++;
                end
                else
                begin
                    shadow_keys[shadow_count] = key;
                    shadow_vals[shadow_count] = val;
                    shadow_count++;
                end
            end
            OP_ERASE:
            begin
                if (slot < 0)
                begin
                    r.status = ST_MISS;
                    key_misses++;
                end
                else
                begin
                    r.found = 1'b1;
                    key_hits++;
                    for (int i = slot; i < shadow_count - 1; i++)
                    begin
                        shadow_keys[i] = shadow_keys[i + 1];
                        shadow_vals[i] = shadow_vals[i + 1];
                    end
                    shadow_count--;
                end
            end
            OP_ERASE_ALL:
                shadow_count = 0;
            OP_GET:
            begin
                if (slot < 0)
                begin
                    r.status = ST_MISS;
                    key_misses++;
                end
                else
                begin
                    r.found = 1'b1;
                    r.value_out = shadow_vals[slot];
                    key_hits++;
                end
            end
            OP_HAS:
                r.found = (slot >= 0);
            OP_COUNT:
            begin
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (shadow_vals[i] == val)
                        r.match_count = r.match_count + 1'b1;
                end
            end
            default: ;
        endcase
        r.occupancy = TALLY_W'(shadow_count);
        if (shadow_count > peak_occupancy)
            peak_occupancy = shadow_count;
        return r;
    endfunction

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [TAG_W-1:0] key,
                                input logic [WORD_W-1:0] val);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.operation  <= op;
        req.key_tag    <= key;
        req.value_word <= val;
        @(negedge clk);
        while (!req.ready)
            @(negedge clk);
        awaited_replies.push_back(apply_to_shadow_table(op, key, val));
        requests_sent++;
        @(posedge clk);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ready only moves at the rising edge, so the falling edge sees what the next edge takes
    always @(negedge clk)
    begin : check_replies
        table_reply_t want;
        if (rst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            if (awaited_replies.size() == 0)
            begin
                $error("result word with nothing outstanding");
                failures++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                check_field("status", 32'(want.status), 32'(rsp.status));
                check_field("found", 32'(want.found), 32'(rsp.found));
                check_field("value_out", want.value_out, rsp.value_out);
                check_field("match_count", 32'(want.match_count), 32'(rsp.match_count));
                check_field("occupancy", 32'(want.occupancy), 32'(rsp.occupancy));
                replies_checked++;
            end
        end
    end

    task automatic test_directed_cases();
        send_request(OP_GET, 32'h0, 32'h0);
        send_request(OP_COUNT, 32'h0, 32'h0);
        send_request(OP_INSERT, 32'h0, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0);
        send_request(OP_INSERT, 32'h0, 32'h5);
        send_request(OP_INSERT, 32'h1, 32'hFFFF_FFFF);
        send_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
        send_request(OP_GET, 32'h0, 32'h0);
        send_request(OP_HAS, 32'h1, 32'h0);
        send_request(OP_HAS, 32'h2, 32'hFFFF_FFFF);
        send_request(OP_COUNT, 32'h0, 32'hFFFF_FFFF);
        send_request(OP_COUNT, 32'hFFFF_FFFF, 32'h0);
        send_request(OP_ERASE, 32'h2, 32'h0);
        // erase of the oldest word shifts the rest down
        send_request(OP_ERASE, 32'h0, 32'h0);
        send_request(OP_GET, 32'h1, 32'h0);
        send_request(OP_SPARE_A, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_SPARE_B, 32'h1, 32'hFFFF_FFFF);
        send_request(OP_ERASE, 32'h1, 32'h0);
        send_request(OP_ERASE_ALL, 32'hFFFF_FFFF, 32'h0);
        send_request(OP_HAS, 32'hFFFF_FFFF, 32'h0);
        send_request(OP_INSERT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_request(OP_ERASE, 32'hA5A5_A5A5, 32'h0);
    endtask

    task automatic test_fill_and_drain(input int rounds);
        logic [WORD_W-1:0] vals [4];
        logic [TAG_W-1:0]  key;
        for (int round = 0; round < rounds; round++)
        begin
            no_idle = (round == 1);
            foreach (vals[i])
                vals[i] = $urandom;
            send_request(OP_ERASE_ALL, $urandom, $urandom);
            while (shadow_count < CAPACITY)
            begin
                key = $urandom;
                if (slot_of(key) < 0)
                    send_request(OP_INSERT, key, vals[$urandom_range(3)]);
            end
            send_request(OP_INSERT, ~shadow_keys[0], $urandom);
            send_request(OP_INSERT, shadow_keys[$urandom_range(CAPACITY - 1)], $urandom);
            foreach (vals[i])
                send_request(OP_COUNT, $urandom, vals[i]);
            send_request(OP_GET, shadow_keys[CAPACITY - 1], $urandom);
            while (shadow_count > 0)
            begin
                key = shadow_keys[$urandom_range(shadow_count - 1)];
                if ($urandom_range(99) < 20)
                    send_request(OP_ERASE, key ^ (32'h1 << $urandom_range(31)), $urandom);
                if ($urandom_range(1))
                    send_request(OP_GET, key, $urandom);
                send_request(OP_ERASE, key, $urandom);
                if ($urandom_range(99) < 15)
                    send_request(OP_COUNT, $urandom, vals[$urandom_range(3)]);
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic(input int n_items);
        logic [TAG_W-1:0]  key_pool [48];
        logic [WORD_W-1:0] val_pool [6];
        logic [TAG_W-1:0]  key;
        logic [WORD_W-1:0] val;
        logic [OP_W-1:0]   op;
        int pick;
        for (int n = 0; n < n_items; n++)
        begin
            if (n % 250 == 0)
            begin
                foreach (key_pool[i])
                    key_pool[i] = $urandom;
                foreach (val_pool[i])
                    val_pool[i] = $urandom;
                key_pool[0] = '0;
                key_pool[1] = '1;
                val_pool[0] = '0;
                val_pool[1] = '1;
            end
            // hold off until the block has answered everything
            if (n % 300 == 150)
            begin
                req.valid <= 1'b0;
                wait (awaited_replies.size() == 0);
                @(posedge clk);
            end
            pick = $urandom_range(99);
            if (pick < 36)
                op = OP_INSERT;
            else if (pick < 50)
                op = OP_ERASE;
            else if (pick < 64)
                op = OP_GET;
            else if (pick < 78)
                op = OP_HAS;
            else if (pick < 92)
                op = OP_COUNT;
            else if (pick < 94)
                op = OP_ERASE_ALL;
            else if (pick < 97)
                op = OP_SPARE_A;
            else
                op = OP_SPARE_B;
            pick = $urandom_range(99);
            if (shadow_count > 0 && pick < 35)
                key = shadow_keys[$urandom_range(shadow_count - 1)];
            else if (pick < 88)
                key = key_pool[$urandom_range(47)];
            else
                key = $urandom;
            if ($urandom_range(99) < 65)
                val = val_pool[$urandom_range(5)];
            else
                val = $urandom;
            send_request(op, key, val);
        end
    endtask

    initial
    begin
        req.valid      <= 1'b0;
        req.operation  <= OP_INSERT;
        req.key_tag    <= '0;
        req.value_word <= '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_fill_and_drain(3);
        test_random_traffic(1100);
        req.valid <= 1'b0;
        wait (awaited_replies.size() == 0);
        repeat (100) @(posedge clk);
        $display("Sent %0d requests, checked %0d replies; peak occupancy %0d.",
                 requests_sent, replies_checked, peak_occupancy);
        $display("Refused %0d inserts as full and %0d as duplicate; %0d key hits, %0d misses.",
                 full_refusals, dup_refusals, key_hits, key_misses);
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timed out with %0d replies outstanding.", awaited_replies.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/kvt_pkg.sv
sv/kvt_req_if.sv
sv/kvt_rsp_if.sv
sv/kvt_ram.sv
sv/kvt_ctrl.sv
sv/kvt_datapath.sv
sv/keyed_value_table_top.sv
dv/keyed_value_table_top_tb.sv
